FILE: design/safc_pkg.sv
// ----------------------------------------------------------------------------
// safc_pkg: shared types and constants of the six-axis force conditioner
// Calibration codes, lane and merge control groups, and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package safc_pkg;

  // Width of one decoupled force term sum (34-bit terms, up to eight of them)
  localparam int FORCE_W = 37;
  localparam int OUT_W   = 48;
  localparam int COL_W   = 3;
  localparam int CNT_W   = 6;
  localparam int IDX_W   = 6;

  // Divide by the window length: reciprocal taken in chunks, high chunk first
  localparam int DIV_CHUNK = 16;
  localparam int DIV_STEPS = 3;

  localparam logic MODE_CAL    = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    CAL_OFFSET   = 2'd0,
    CAL_SCALE    = 2'd1,
    CAL_DEADBAND = 2'd2,
    CAL_COEF     = 2'd3
  } cal_kind_e;

  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_LOAD,
    LOP_SCALE,
    LOP_CHAN,
    LOP_MAC
  } lane_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CHAN,
    ST_MAC,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               en;
    cal_kind_e          kind;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] value;
  } cal_wr_t;

  typedef struct packed {
    lane_op_e         op;
    logic [COL_W-1:0] col;
    logic             acc_en;
  } lane_ctl_t;

  typedef struct packed {
    logic start;
    logic step;
    logic load;
  } mrg_ctl_t;

endpackage

`default_nettype wire

FILE: design/six_axis_force_conditioner.sv
// A sample beat passes through scale, channel rounding, CHANNELS + 1 column steps
// of the row products, window update, DIV_STEPS reciprocal-multiply steps of the
// divide and output load. No new sample beat is taken until its result is loaded
// into the output; a stalled result holds the input. Calibration beats are taken
// while idle and leave the block ready.
// Reset clears calibration, history and baseline; the first sample sets baseline.
// ----------------------------------------------------------------------------
// six_axis_force_conditioner: six-axis load cell conditioning
// Offset, scale, matrix decoupling, window average with baseline, deadband.
// ----------------------------------------------------------------------------
`default_nettype none

module six_axis_force_conditioner import safc_pkg::*; #(
  parameter int CHANNELS = 6,
  parameter int WINDOW   = 5
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    mode_i,
  input  wire logic [1:0]              cal_kind_i,
  input  wire logic [5:0]              cal_index_i,
  input  wire logic signed [31:0]      cal_value_i,
  input  wire logic [15:0]             count_0_i,
  input  wire logic [15:0]             count_1_i,
  input  wire logic [15:0]             count_2_i,
  input  wire logic [15:0]             count_3_i,
  input  wire logic [15:0]             count_4_i,
  input  wire logic [15:0]             count_5_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [OUT_W-1:0]      force_x_o,
  output logic signed [OUT_W-1:0]      force_y_o,
  output logic signed [OUT_W-1:0]      force_z_o,
  output logic signed [OUT_W-1:0]      torque_x_o,
  output logic signed [OUT_W-1:0]      torque_y_o,
  output logic signed [OUT_W-1:0]      torque_z_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  lane_ctl_t          lane_ctl;
  mrg_ctl_t           mrg_ctl;
  cal_wr_t            cal_wr;

  logic [15:0]               count_in [6];
  logic signed [31:0]        chan [CHANNELS];
  logic signed [FORCE_W-1:0] force_v [CHANNELS];
  logic signed [31:0]        deadband [CHANNELS];
  logic signed [OUT_W-1:0]   axis [CHANNELS];
  logic signed [OUT_W-1:0]   axis_out [6];

  assign count_in[0] = count_0_i;
  assign count_in[1] = count_1_i;
  assign count_in[2] = count_2_i;
  assign count_in[3] = count_3_i;
  assign count_in[4] = count_4_i;
  assign count_in[5] = count_5_i;

  assign in_stall_o = (state_q != ST_IDLE);

  // Route calibration beats to the lanes
  assign cal_wr.en    = (state_q == ST_IDLE) && in_valid_i && (mode_i == MODE_CAL);
  assign cal_wr.kind  = cal_kind_e'(cal_kind_i);
  assign cal_wr.idx   = cal_index_i;
  assign cal_wr.value = cal_value_i;

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Step through scale, row products, window and divide
  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    lane_ctl.op     = LOP_NONE;
    lane_ctl.col    = cnt_q[COL_W-1:0];
    lane_ctl.acc_en = 1'b0;
    mrg_ctl         = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (mode_i == MODE_SAMPLE)) begin
          lane_ctl.op = LOP_LOAD;
          state_d     = ST_SCALE;
        end
      end
      ST_SCALE: begin
        lane_ctl.op = LOP_SCALE;
        state_d     = ST_CHAN;
      end
      ST_CHAN: begin
        lane_ctl.op = LOP_CHAN;
        cnt_d       = '0;
        state_d     = ST_MAC;
      end
      ST_MAC: begin
        if (cnt_q < CNT_W'(CHANNELS)) begin
          lane_ctl.op = LOP_MAC;
        end
        lane_ctl.acc_en = (cnt_q != '0);
        if (cnt_q == CNT_W'(CHANNELS)) begin
          state_d = ST_SUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SUM: begin
        mrg_ctl.start = 1'b1;
        cnt_d         = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        mrg_ctl.step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_o || !out_stall_i) begin
          mrg_ctl.load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar r = 0; r < CHANNELS; r++) begin : g_lane
    logic [15:0] lane_count;
    if (r < 6) begin : g_cnt
      assign lane_count = count_in[r];
    end else begin : g_nocnt
      assign lane_count = '0;
    end

    safc_lane #(
      .CHANNELS (CHANNELS),
      .LANE     (r)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cal_i      (cal_wr),
      .ctl_i      (lane_ctl),
      .count_i    (lane_count),
      .chan_i     (chan),
      .chan_o     (chan[r]),
      .force_o    (force_v[r]),
      .deadband_o (deadband[r])
    );
  end

  safc_merge #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mrg_ctl),
    .force_i     (force_v),
    .deadband_i  (deadband),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .axis_o      (axis)
  );

  // Tie off axes without a channel
  for (genvar a = 0; a < 6; a++) begin : g_out
    if (a < CHANNELS) begin : g_on
      assign axis_out[a] = axis[a];
    end else begin : g_off
      assign axis_out[a] = '0;
    end
  end

  assign force_x_o  = axis_out[0];
  assign force_y_o  = axis_out[1];
  assign force_z_o  = axis_out[2];
  assign torque_x_o = axis_out[3];
  assign torque_y_o = axis_out[4];
  assign torque_z_o = axis_out[5];

endmodule

`default_nettype wire

FILE: design/safc_lane.sv
// ----------------------------------------------------------------------------
// safc_lane: one channel and one matrix row
// Holds the channel's calibration and its matrix row, scales the count and
// accumulates the row product over the columns with one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module safc_lane import safc_pkg::*; #(
  parameter int CHANNELS = 6,
  parameter int LANE     = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cal_wr_t                   cal_i,
  input  wire lane_ctl_t                 ctl_i,
  input  wire logic [15:0]               count_i,
  input  wire logic signed [31:0]        chan_i [CHANNELS],
  output logic signed [31:0]             chan_o,
  output logic signed [FORCE_W-1:0]      force_o,
  output logic signed [31:0]             deadband_o
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [23:0]        offset_q;
  logic signed [31:0]        scale_q;
  logic signed [31:0]        deadband_q;
  logic signed [31:0]        coef_q [CHANNELS];
  logic [15:0]               count_q;
  logic signed [63:0]        prod_q;
  logic signed [31:0]        chan_q;
  logic signed [FORCE_W-1:0] acc_q;

  logic signed [25:0] diff;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] chan_rnd;
  logic signed [63:0] term_rnd;
  logic signed [31:0] chan_d;
  logic [CW-1:0]      col;

  assign col = ctl_i.col[CW-1:0];

  // Form (count << 8) - offset and pick the multiplier operands
  assign diff  = $signed({2'b00, count_q, 8'h00}) - {{2{offset_q[23]}}, offset_q};
  assign mul_a = (ctl_i.op == LOP_MAC) ? chan_i[col] : {{6{diff[25]}}, diff};
  assign mul_b = (ctl_i.op == LOP_MAC) ? coef_q[col] : scale_q;
  assign prod  = mul_a * mul_b;

  // Round the scaled channel to Q8.24 and saturate to 32 bits
  always_comb begin
    chan_rnd = (prod_q + 64'sd8192) >>> 14;
    if (chan_rnd > 64'sh000000007FFFFFFF) begin
      chan_d = 32'sh7FFFFFFF;
    end else if (chan_rnd < 64'shFFFFFFFF80000000) begin
      chan_d = 32'sh80000000;
    end else begin
      chan_d = chan_rnd[31:0];
    end
  end

  // Round one matrix term to Q.16
  assign term_rnd = (prod_q + 64'sd536870912) >>> 30;

  // Take calibration beats addressed to this lane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      scale_q    <= '0;
      deadband_q <= '0;
    end else if (cal_i.en && (cal_i.idx == IDX_W'(LANE))) begin
      case (cal_i.kind)
        CAL_OFFSET:   offset_q   <= cal_i.value[23:0];
        CAL_SCALE:    scale_q    <= cal_i.value;
        CAL_DEADBAND: deadband_q <= cal_i.value;
        default: ;
      endcase
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_coef
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        coef_q[c] <= '0;
      end else if (cal_i.en && (cal_i.kind == CAL_COEF) &&
                   (cal_i.idx == IDX_W'(LANE * CHANNELS + c))) begin
        coef_q[c] <= cal_i.value;
      end
    end
  end

  // Advance the datapath one step per cycle
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      LOP_LOAD:  count_q <= count_i;
      LOP_SCALE: prod_q  <= prod;
      LOP_CHAN:  chan_q  <= chan_d;
      LOP_MAC:   prod_q  <= prod;
      default: ;
    endcase
    if (ctl_i.op == LOP_SCALE) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + term_rnd[FORCE_W-1:0];
    end
  end

  assign chan_o     = chan_q;
  assign force_o    = acc_q;
  assign deadband_o = deadband_q;

endmodule

`default_nettype wire

FILE: design/safc_merge.sv
// ----------------------------------------------------------------------------
// safc_merge: window, baseline, divide and deadband for every axis
// Keeps a running window sum per axis, removes the first-sum baseline,
// divides by the window length with a chunked reciprocal multiply, holds the
// result.
// ----------------------------------------------------------------------------
`default_nettype none

module safc_merge import safc_pkg::*; #(
  parameter int CHANNELS = 6,
  parameter int WINDOW   = 5
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mrg_ctl_t                  ctl_i,
  input  wire logic signed [FORCE_W-1:0] force_i [CHANNELS],
  input  wire logic signed [31:0]        deadband_i [CHANNELS],
  input  wire logic                      out_stall_i,
  output logic                           out_valid_o,
  output logic signed [OUT_W-1:0]        axis_o [CHANNELS]
);

  localparam int HIST   = WINDOW - 1;
  localparam int SUM_W  = FORCE_W + $clog2(WINDOW);
  localparam int DIV_W  = SUM_W + 1;
  localparam int RCP_L  = $clog2(WINDOW);
  localparam int RCP_SH = DIV_W + RCP_L;
  localparam int RCP_W  = DIV_STEPS * DIV_CHUNK;
  localparam int PRD_W  = DIV_W + DIV_CHUNK;
  localparam int ACC_W  = DIV_W + RCP_W;

  // floor(2^RCP_SH / WINDOW) + 1 gives an exact quotient for any magnitude
  localparam logic [63:0]      RCP_WIDE = ((64'd1 << RCP_SH) / 64'(WINDOW)) + 64'd1;
  localparam logic [RCP_W-1:0] RCP      = RCP_W'(RCP_WIDE);

  logic pending_q;
  logic out_valid_q;
  logic [RCP_W-1:0]     rcp_q;
  logic [DIV_CHUNK-1:0] rcp_chunk;

  // Drop the pending baseline after the first sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b1;
    end else if (ctl_i.start) begin
      pending_q <= 1'b0;
    end
  end

  // Hold the result until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // Present the reciprocal one chunk per step, high chunk first
  assign rcp_chunk = rcp_q[RCP_W-1 -: DIV_CHUNK];

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rcp_q <= RCP;
    end else if (ctl_i.step) begin
      rcp_q <= {rcp_q[RCP_W-DIV_CHUNK-1:0], {DIV_CHUNK{1'b0}}};
    end
  end

  for (genvar r = 0; r < CHANNELS; r++) begin : g_axis
    logic signed [FORCE_W-1:0] hist_q [HIST];
    logic signed [SUM_W-1:0]   win_q;
    logic signed [SUM_W-1:0]   base_q;
    logic [DIV_W-1:0]          mag_q;
    logic [ACC_W-1:0]          acc_q;
    logic                      neg_q;
    logic signed [OUT_W-1:0]   axis_q;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] win_d;
    logic signed [DIV_W-1:0] diff;
    logic [DIV_W-1:0]        mag;
    logic [PRD_W-1:0]        part;
    logic [DIV_W-1:0]        quo;
    logic                    below;
    logic signed [OUT_W-1:0] qext;

    assign sum   = win_q + SUM_W'(force_i[r]);
    assign win_d = sum - SUM_W'(hist_q[HIST-1]);
    assign diff  = DIV_W'(sum) - DIV_W'(pending_q ? sum : base_q);
    assign mag   = diff[DIV_W-1] ? DIV_W'(-diff) : DIV_W'(diff);

    // One partial product of the magnitude and a reciprocal chunk
    assign part = PRD_W'(mag_q) * PRD_W'(rcp_chunk);
    assign quo  = acc_q[RCP_SH +: DIV_W];

    // Zero magnitudes under a non-negative deadband
    assign below = !deadband_i[r][31] && (quo < DIV_W'(deadband_i[r][30:0]));
    assign qext  = $signed(OUT_W'(quo));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        win_q  <= '0;
        base_q <= '0;
        for (int h = 0; h < HIST; h++) begin
          hist_q[h] <= '0;
        end
      end else if (ctl_i.start) begin
        win_q <= win_d;
        if (pending_q) begin
          base_q <= sum;
        end
        hist_q[0] <= force_i[r];
        for (int h = 1; h < HIST; h++) begin
          hist_q[h] <= hist_q[h-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.start) begin
        mag_q <= mag;
        acc_q <= '0;
        neg_q <= diff[DIV_W-1];
      end else if (ctl_i.step) begin
        acc_q <= {acc_q[ACC_W-DIV_CHUNK-1:0], {DIV_CHUNK{1'b0}}} + ACC_W'(part);
      end
      if (ctl_i.load) begin
        if (below) begin
          axis_q <= '0;
        end else begin
          axis_q <= neg_q ? -qext : qext;
        end
      end
    end

    assign axis_o[r] = axis_q;
  end

endmodule

`default_nettype wire

FILE: design/safc_checker.sv
// ----------------------------------------------------------------------------
// safc_checker: port-level checks of the force conditioner
// Watches the beat handshakes and the sequencing seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module safc_checker import safc_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   mode_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic signed [OUT_W-1:0] force_x_o
);

  // A sample beat occupies the block on the next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (mode_i == MODE_SAMPLE)) |=> in_stall_o)
    else $error("block not busy after a sample beat");

  // A calibration beat leaves the block ready
  a_cal_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (mode_i == MODE_CAL)) |=> !in_stall_o)
    else $error("block busy after a calibration beat");

  // A result cannot follow a sample beat in the very next cycle
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (mode_i == MODE_SAMPLE) && !out_valid_o)
    |=> !out_valid_o)
    else $error("result appeared too early");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(force_x_o)))
    else $error("stalled result beat changed");

endmodule

bind six_axis_force_conditioner safc_checker u_safc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .force_x_o   (force_x_o)
);

`default_nettype wire

FILE: sim/tb_six_axis_force_conditioner.sv
// ----------------------------------------------------------------------------
// tb_six_axis_force_conditioner: self-checking bench of the force conditioner
// Drives calibration and sample beats with random gaps, predicts each force
// vector in a local model of the datapath and checks the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_six_axis_force_conditioner;
  import safc_pkg::*;

  localparam int NCH     = 6;
  localparam int WIN     = 5;
  localparam int HIST    = WIN - 1;
  localparam int N_RAND  = 1150;
  localparam int LIMIT   = 3000000;
  localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;

  typedef struct {
    logic        mode;
    logic [1:0]  kind;
    logic [5:0]  idx;
    logic [31:0] value;
    logic [15:0] cnt [NCH];
  } beat_t;

  typedef struct {
    logic [47:0] axis [NCH];
  } wrench_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic mode;
  logic [1:0] cal_kind;
  logic [5:0] cal_index;
  logic signed [31:0] cal_value;
  logic [15:0] cnt0, cnt1, cnt2, cnt3, cnt4, cnt5;
  logic signed [47:0] fx, fy, fz, tx, ty, tz;

  six_axis_force_conditioner dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .cal_kind_i(cal_kind), .cal_index_i(cal_index),
    .cal_value_i(cal_value),
    .count_0_i(cnt0), .count_1_i(cnt1), .count_2_i(cnt2),
    .count_3_i(cnt3), .count_4_i(cnt4), .count_5_i(cnt5),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .force_x_o(fx), .force_y_o(fy), .force_z_o(fz),
    .torque_x_o(tx), .torque_y_o(ty), .torque_z_o(tz)
  );

  // Predictor state
  longint offs [NCH], scl [NCH], dband [NCH], coef [NCH*NCH];
  longint hist [HIST][NCH], base [NCH];
  bit     base_pending;

  beat_t   pending_beats [$];
  wrench_t expected_wrenches [$];
  int      errors, cycles;
  bit      long_hold;

  function automatic longint round_sh(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Apply one accepted beat to the local model
  task automatic predict_beat(beat_t b);
    longint chan [NCH], frc [NCH];
    longint acc, sum, val, mag;
    wrench_t w;
    if (b.mode == MODE_CAL) begin
      if (b.kind == CAL_COEF) begin
        if (b.idx < NCH*NCH) coef[b.idx] = longint'($signed(b.value));
      end else if (b.idx < NCH) begin
        case (b.kind)
          CAL_OFFSET: offs[b.idx] = longint'($signed(b.value[23:0]));
          CAL_SCALE:  scl[b.idx]  = longint'($signed(b.value));
          default:    dband[b.idx] = longint'($signed(b.value));
        endcase
      end
    end else begin
      for (int c = 0; c < NCH; c++)
        chan[c] = clamp(round_sh((longint'(b.cnt[c]) * 256 - offs[c]) * scl[c], 14),
                        -64'sd2147483648, 64'sd2147483647);
      for (int r = 0; r < NCH; r++) begin
        acc = 0;
        for (int c = 0; c < NCH; c++)
          acc += round_sh(chan[c] * coef[r*NCH + c], 30);
        frc[r] = clamp(acc, MIN48, MAX48);
      end
      for (int r = 0; r < NCH; r++) begin
        sum = frc[r];
        for (int h = 0; h < HIST; h++) sum += hist[h][r];
        if (base_pending) base[r] = sum;
        val = clamp((sum - base[r]) / WIN, MIN48, MAX48);
        mag = val < 0 ? -val : val;
        if (mag < dband[r]) val = 0;
        w.axis[r] = val[47:0];
      end
      base_pending = 0;
      for (int r = 0; r < NCH; r++) begin
        for (int h = HIST - 1; h > 0; h--) hist[h][r] = hist[h-1][r];
        hist[0][r] = frc[r];
      end
      expected_wrenches.push_back(w);
    end
  endtask

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  function automatic beat_t cal_beat(logic [1:0] k, logic [5:0] i, logic [31:0] v);
    beat_t b;
    b.mode = MODE_CAL; b.kind = k; b.idx = i; b.value = v;
    foreach (b.cnt[c]) b.cnt[c] = 16'($urandom);
    return b;
  endfunction

  function automatic beat_t sample_beat(logic [15:0] lo, logic [15:0] hi);
    beat_t b;
    b.mode = MODE_SAMPLE; b.kind = 2'($urandom); b.idx = 6'($urandom);
    b.value = $urandom;
    foreach (b.cnt[c]) b.cnt[c] = 16'($urandom_range(lo, hi));
    return b;
  endfunction

  // Clock and reset
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
  end

  initial begin
    foreach (offs[c]) begin offs[c] = 0; scl[c] = 0; dband[c] = 0; base[c] = 0; end
    foreach (coef[i]) coef[i] = 0;
    foreach (hist[h, c]) hist[h][c] = 0;
    base_pending = 1;
  end

  // Driver: offer queued beats with random gaps
  int gap;
  beat_t cur;
  initial begin
    in_valid = 0; mode = 0; cal_kind = 0; cal_index = 0; cal_value = 0;
    cnt0 = 0; cnt1 = 0; cnt2 = 0; cnt3 = 0; cnt4 = 0; cnt5 = 0;
    gap = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_beat(cur);
      if (!(in_valid && in_stall)) begin
        if (gap > 0 || pending_beats.size() == 0) begin
          in_valid <= 0;
          if (gap > 0) gap <= gap - 1;
        end else begin
          cur = pending_beats.pop_front();
          in_valid <= 1;
          mode <= cur.mode; cal_kind <= cur.kind; cal_index <= cur.idx;
          cal_value <= cur.value;
          cnt0 <= cur.cnt[0]; cnt1 <= cur.cnt[1]; cnt2 <= cur.cnt[2];
          cnt3 <= cur.cnt[3]; cnt4 <= cur.cnt[4]; cnt5 <= cur.cnt[5];
          gap <= gap_len();
        end
      end
    end
  end

  // Monitor: random stall, compare each result with the oldest expectation
  int hold;
  initial begin out_stall = 0; hold = 0; end

  always @(posedge clk) begin
    logic [47:0] got [NCH];
    wrench_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got[0] = fx; got[1] = fy; got[2] = fz; got[3] = tx; got[4] = ty; got[5] = tz;
        if (expected_wrenches.size() == 0) begin
          report_mismatch("unexpected beat, axis 0", got[0], 48'd0);
        end else begin
          w = expected_wrenches.pop_front();
          for (int r = 0; r < NCH; r++)
            if (got[r] !== w.axis[r]) report_mismatch($sformatf("axis %0d", r), got[r], w.axis[r]);
        end
      end
      if (long_hold) out_stall <= 1;
      else if (hold > 0) begin out_stall <= 1; hold <= hold - 1; end
      else if ($urandom_range(0, 3) == 0) begin out_stall <= 1; hold <= gap_len(); end
      else out_stall <= 0;
    end
  end

  // Cycle limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_six_axis_force_conditioner NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_wrenches.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    beat_t b;
    int k;
    errors = 0; long_hold = 0;
    @(posedge rst_n);

    // Directed: unity scales, identity matrix, zero deadband
    for (int c = 0; c < NCH; c++) begin
      pending_beats.push_back(cal_beat(CAL_SCALE, 6'(c), 32'h4000_0000));
      pending_beats.push_back(cal_beat(CAL_COEF, 6'(c*NCH + c), 32'h0040_0000));
    end
    pending_beats.push_back(sample_beat(16'd0, 16'd0));
    pending_beats.push_back(sample_beat(16'hFFFF, 16'hFFFF));
    pending_beats.push_back(sample_beat(16'd0, 16'd0));
    // Out-of-range indexes are ignored
    pending_beats.push_back(cal_beat(CAL_OFFSET, 6'd6, 32'h7FFF_FFFF));
    pending_beats.push_back(cal_beat(CAL_COEF, 6'd36, 32'h8000_0000));
    pending_beats.push_back(cal_beat(CAL_DEADBAND, 6'd63, 32'h1));
    // Extreme scale and offset saturate the channel value
    pending_beats.push_back(cal_beat(CAL_SCALE, 6'd0, 32'h7FFF_FFFF));
    pending_beats.push_back(cal_beat(CAL_OFFSET, 6'd1, 32'h0080_0000));
    pending_beats.push_back(cal_beat(CAL_DEADBAND, 6'd2, 32'h8000_0000));
    pending_beats.push_back(sample_beat(16'hFFFF, 16'hFFFF));
    pending_beats.push_back(sample_beat(16'd0, 16'd0));
    pending_beats.push_back(cal_beat(CAL_COEF, 6'd5, 32'h8000_0000));
    pending_beats.push_back(sample_beat(16'hFFFF, 16'hFFFF));
    wait_drained();

    // Sender pause until drained already done; now a long receiver hold
    long_hold = 1;
    for (int i = 0; i < 6; i++) pending_beats.push_back(sample_beat(16'd0, 16'hFFFF));
    k = 0;
    while (k < 400) begin @(posedge clk); k++; end
    long_hold = 0;
    wait_drained();

    // Random: mostly samples with occasional calibration rewrites
    for (int i = 0; i < N_RAND; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(0, 3);
        b = cal_beat(2'(k),
                     6'((k == CAL_COEF) ? $urandom_range(0, 37) : $urandom_range(0, 7)),
                     ($urandom_range(0, 7) == 0) ? {$urandom_range(0,1) ? 32'h7FFF_FFFF
                                                   : 32'h8000_0000} : $urandom);
        if (k == CAL_DEADBAND && $urandom_range(0, 1)) b.value = $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 15) == 0) b.idx = 6'($urandom);
      end else begin
        b = ($urandom_range(0, 9) == 0) ? sample_beat(16'hFFF0, 16'hFFFF)
                                       : sample_beat(16'd0, 16'hFFFF);
      end
      pending_beats.push_back(b);
      // Pause the sender until every expected result has come back
      if (i % 200 == 199) wait_drained();
    end
    wait_drained();

    if (errors == 0 && expected_wrenches.size() == 0)
      $display("tb_six_axis_force_conditioner OK");
    else
      $display("tb_six_axis_force_conditioner NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
